// File: rtl/core/hbhe_pkg.sv
// Package with the constants, types and hex helpers of the high-byte hex escape codec.
`timescale 1ns / 1ps

package hbhe_pkg;

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam int unsigned MAX_RESULTS = 3;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       bad;
	} result_t;

	// Lower-case hex digit for a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h61 + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

	// Nibble value of a hex digit of either case; bit 4 is set when the byte is not one.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = {1'b0, 4'(b - 8'h61 + 8'd10)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = {1'b0, 4'(b - 8'h41 + 8'd10)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

// File: rtl/core/high_byte_hex_escape_codec.sv
// Path: the results of a request are registered in the result buffer and then in the byte-wide
// output register. A new request is taken only when the buffer is empty or its last result
// is being drained. The output register drains the result buffer one byte per cycle while
// the output is not stalled by m_axis_tready.
// Reset: arst_n clears mode to encode, the hex run and pending digit flags, and all valids.
`timescale 1ns / 1ps

module high_byte_hex_escape_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,     // mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic       m_axis_tlast,  // last
	output logic       m_axis_tuser   // bad_pair
);
	import hbhe_pkg::*;

	logic       mode_q;
	logic       in_hex_run_q;
	logic       half_pending_q;
	logic [7:0] held_digit_q;

	result_t    res_s1 [MAX_RESULTS];
	logic [1:0] buf_cnt_q;

	logic       m_valid_q;
	logic [7:0] m_byte_q;
	logic       m_last_q;
	logic       m_bad_q;

	logic       pop;
	logic       s_hs;

	result_t    new_res [MAX_RESULTS];
	logic [1:0] new_cnt;
	logic       nxt_run;
	logic       nxt_half;
	logic       load_held;
	logic [4:0] hi_v;
	logic [4:0] lo_v;

	assign pop           = (buf_cnt_q != 2'd0) && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = (buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && pop);
	assign s_hs          = s_axis_tvalid && s_axis_tready;

	assign hi_v = hex_value(held_digit_q);
	assign lo_v = hex_value(s_axis_tdata);

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			new_res[i] = '{data: 8'h00, bad: 1'b0};
		end
		new_cnt   = 2'd0;
		nxt_run   = in_hex_run_q;
		nxt_half  = half_pending_q;
		load_held = 1'b0;
		case (mode_q)
			MODE_ENCODE: begin
				if (s_axis_tdata[7]) begin
					nxt_run = 1'b1;
					if (!in_hex_run_q) begin
						new_res[0].data = ESC_BYTE;
						new_res[1].data = hex_char(s_axis_tdata[7:4]);
						new_res[2].data = hex_char(s_axis_tdata[3:0]);
						new_cnt         = 2'd3;
					end else begin
						new_res[0].data = hex_char(s_axis_tdata[7:4]);
						new_res[1].data = hex_char(s_axis_tdata[3:0]);
						new_cnt         = 2'd2;
					end
				end else begin
					nxt_run = 1'b0;
					if (in_hex_run_q) begin
						new_res[0].data = ESC_BYTE;
						new_res[1].data = s_axis_tdata;
						new_cnt         = 2'd2;
					end else begin
						new_res[0].data = s_axis_tdata;
						new_cnt         = 2'd1;
					end
				end
			end
			MODE_DECODE: begin
				if (half_pending_q) begin
					nxt_half = 1'b0;
					new_cnt  = 2'd1;
					if (!hi_v[4] && !lo_v[4]) begin
						new_res[0].data = {hi_v[3:0], lo_v[3:0]};
					end else begin
						new_res[0].data = held_digit_q;
						new_res[0].bad  = 1'b1;
					end
				end else if (s_axis_tdata == ESC_BYTE) begin
					nxt_run = !in_hex_run_q;
				end else if (in_hex_run_q) begin
					load_held = 1'b1;
					nxt_half  = 1'b1;
				end else begin
					new_res[0].data = s_axis_tdata;
					new_cnt         = 2'd1;
				end
			end
			default: begin
				new_cnt = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_ENCODE;
			in_hex_run_q   <= 1'b0;
			half_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (s_hs) begin
				in_hex_run_q   <= nxt_run;
				half_pending_q <= nxt_half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_hs && load_held) begin
			held_digit_q <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 2'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_hs) begin
				buf_cnt_q <= new_cnt;
			end else if (pop) begin
				buf_cnt_q <= buf_cnt_q - 2'd1;
			end
			if (pop) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_hs) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_s1[i] <= new_res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_s1[i] <= res_s1[i + 1];
			end
		end
		if (pop) begin
			m_byte_q <= res_s1[0].data;
			m_bad_q  <= res_s1[0].bad;
			m_last_q <= (buf_cnt_q == 2'd1);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_byte_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_bad_q;

`ifndef SYNTHESIS
	// A new request is only taken when at most one buffered result is left.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (buf_cnt_q == 2'd0 || buf_cnt_q == 2'd1))
		else $error("input ready while the result buffer is still full");

	// An encoded high byte leaves at least two results in the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_hs && (mode_q == MODE_ENCODE) && s_axis_tdata[7]
		|=> (buf_cnt_q == 2'd2 || buf_cnt_q == 2'd3))
		else $error("encoded high byte did not yield two hex digits");

	// A flagged pair is always the only, and hence final, result of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("bad pair result not marked as last");
`endif

endmodule
